@@ hw/rtl/fcs_pkg.sv @@
`default_nettype none

package fcs_pkg;

    // Fixed field widths of the request and result payloads.
    localparam int MASK_W     = 4;
    localparam int PRIO_W     = 4;
    localparam int VR_W       = 32;
    localparam int CHOSEN_W   = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Number of priority registers on the configuration port.
    localparam int NUM_PRIO_REGS = 4;

    // A priority weight at or above this marks the context idle.
    localparam logic [PRIO_W-1:0] IDLE_PRIO = 4'd5;

    // Register indexes (byte address is 4 * index).
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_CAP  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRIO_CTX0   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRIO_CTX1   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRIO_CTX2   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PRIO_CTX3   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_POLICY_MODE = 3'd5;

    // Pick policies.
    localparam logic POLICY_FAIR = 1'b0;
    localparam logic POLICY_RR   = 1'b1;

    typedef struct packed {
        logic [MASK_W-1:0] valid_mask;
        logic [MASK_W-1:0] queue_ready_mask;
        logic              skip_current;
    } req_t;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen_context;
        logic                no_valid;
        logic [MASK_W-1:0]   released_mask;
        logic [MASK_W-1:0]   admitted_mask;
        logic                period_reset;
    } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/fair_context_scheduler.sv @@
`default_nettype none

// Fair context scheduler. Each request carries the valid-context mask, the
// per-context queue-ready mask and a bias flag; each request yields exactly
// one result: the context to run next, the contexts released and admitted on
// this request, a period-reset flag, and a no_valid flag when the valid mask
// is empty (the scheduler state is then left untouched). Contexts that leave
// the valid set are released and their virtual runtime parked at mark_vr;
// newly valid contexts with a ready queue are admitted at the lowest
// virtual runtime of the admitted valid contexts. The current context is
// charged its priority weight, saturating at the period cap (or at all ones
// when the cap is 0). Once every valid non-idle context reaches the period,
// the valid runtimes restart. policy_mode selects the lowest-runtime pick or
// round robin with a priority override; weights of 5 and up mark a context
// idle. One request is taken per clock while the result side does not
// stall; each passes the request register, then the result register, and
// the whole decision (runtime update, period check and pick) is evaluated
// between those registers, using all-pairs compares across the contexts, so
// that the state written at the end of one request is ready for the next.
// A stalled result holds the request stage, and req_stall follows from it.
// Registers at byte address 4*i: period_cap, prio_ctx0..3, policy_mode.

module fair_context_scheduler
    import fcs_pkg::*;
#(
    parameter int CONTEXTS = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire req_t                  req_data,

    output logic                       res_valid,
    input  wire logic                  res_stall,
    output res_t                       res_data,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int IW = $clog2(CONTEXTS);
    localparam int RW = $clog2(CONTEXTS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [VR_W-1:0]   period_reg;
    logic [PRIO_W-1:0] prio_reg [NUM_PRIO_REGS];
    logic              policy_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            policy_reg <= POLICY_FAIR;
            for (int i = 0; i < NUM_PRIO_REGS; i++)
            begin
                prio_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_PERIOD_CAP:   period_reg  <= pwdata;
                REG_PRIO_CTX0:    prio_reg[0] <= pwdata[PRIO_W-1:0];
                REG_PRIO_CTX1:    prio_reg[1] <= pwdata[PRIO_W-1:0];
                REG_PRIO_CTX2:    prio_reg[2] <= pwdata[PRIO_W-1:0];
                REG_PRIO_CTX3:    prio_reg[3] <= pwdata[PRIO_W-1:0];
                REG_POLICY_MODE:  policy_reg  <= pwdata[0];
                default:          ; // unmapped: drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PERIOD_CAP:   prdata = period_reg;
            REG_PRIO_CTX0:    prdata = CFG_DATA_W'(prio_reg[0]);
            REG_PRIO_CTX1:    prdata = CFG_DATA_W'(prio_reg[1]);
            REG_PRIO_CTX2:    prdata = CFG_DATA_W'(prio_reg[2]);
            REG_PRIO_CTX3:    prdata = CFG_DATA_W'(prio_reg[3]);
            REG_POLICY_MODE:  prdata = CFG_DATA_W'(policy_reg);
            default:          prdata = '0;
        endcase
    end

    // Priority weight per context; contexts beyond the register file weigh 0.
    logic [PRIO_W-1:0] prio_ctx [CONTEXTS];
    logic [CONTEXTS-1:0] active;

    for (genvar g = 0; g < CONTEXTS; g++)
    begin : g_prio
        if (g < NUM_PRIO_REGS)
        begin : g_reg
            assign prio_ctx[g] = prio_reg[g];
        end
        else
        begin : g_zero
            assign prio_ctx[g] = '0;
        end
        assign active[g] = prio_ctx[g] < IDLE_PRIO;
    end

    // ------------------------------------------------------------------
    // Request register and result register
    // ------------------------------------------------------------------
    logic  s1_valid_reg, s1_valid_next;
    req_t  s1_data_reg;
    logic  res_valid_reg, res_valid_next;
    res_t  res_data_reg;
    res_t  res_calc;
    logic  req_take;
    logic  advance;

    // Advance the request stage whenever the result register frees up.
    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_data_reg <= req_data;
        end
        if (advance)
        begin
            res_data_reg <= res_calc;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // ------------------------------------------------------------------
    // Scheduler state
    // ------------------------------------------------------------------
    logic [CONTEXTS-1:0] prev_valid_reg, prev_valid_next;
    logic [CONTEXTS-1:0] admitted_reg, admitted_next;
    logic [IW-1:0]       current_reg, current_next;
    logic [RW-1:0]       rot_reg, rot_next;
    logic [VR_W-1:0]     vr_reg  [CONTEXTS];
    logic [VR_W-1:0]     vr_next [CONTEXTS];

    // Decision datapath signals
    logic [CONTEXTS-1:0] vld, rdy, removed, kept_adm, min_cand, is_min;
    logic [CONTEXTS-1:0] admit, below, elig, win_fair, win_rr, first_rr, win;
    logic [VR_W-1:0]     vr1 [CONTEXTS];
    logic [VR_W-1:0]     vr2 [CONTEXTS];
    logic [VR_W-1:0]     vr3 [CONTEXTS];
    logic [IW-1:0]       pos [CONTEXTS];
    logic [VR_W-1:0]     min_vr, charged, mark_vr;
    logic [VR_W:0]       sum;
    logic [IW-1:0]       start_pos, chosen, first_idx;
    logic                expired, any_elig, period_on, step_en;

    assign vld       = CONTEXTS'(s1_data_reg.valid_mask);
    assign rdy       = CONTEXTS'(s1_data_reg.queue_ready_mask);
    assign period_on = period_reg != '0;
    assign mark_vr   = period_on ? period_reg - VR_W'(1) : '0;

    always_comb
    begin
        // Release contexts that left the valid set.
        removed  = prev_valid_reg & ~vld;
        kept_adm = admitted_reg & ~removed;

        // Lowest runtime among admitted valid contexts, by all-pairs compare.
        min_cand = vld & kept_adm;
        for (int c = 0; c < CONTEXTS; c++)
        begin
            is_min[c] = min_cand[c];
            for (int d = 0; d < CONTEXTS; d++)
            begin
                if (d < c && min_cand[d] && vr_reg[d] <= vr_reg[c])
                begin
                    is_min[c] = 1'b0;
                end
                if (d > c && min_cand[d] && vr_reg[d] < vr_reg[c])
                begin
                    is_min[c] = 1'b0;
                end
            end
        end
        min_vr = '0;
        for (int c = 0; c < CONTEXTS; c++)
        begin
            if (is_min[c])
            begin
                min_vr = min_vr | vr_reg[c];
            end
        end

        // Admit new contexts whose queue is ready.
        admit = vld & ~prev_valid_reg & rdy;
        for (int c = 0; c < CONTEXTS; c++)
        begin
            if (removed[c])
            begin
                vr1[c] = '0;
            end
            else if (admit[c])
            begin
                vr1[c] = min_vr;
            end
            else
            begin
                vr1[c] = vr_reg[c];
            end
        end

        // Charge the current context, saturating.
        sum = {1'b0, vr1[current_reg]} + (VR_W + 1)'(prio_ctx[current_reg]);
        if (period_on && sum >= {1'b0, period_reg})
        begin
            charged = period_reg;
        end
        else if (sum[VR_W])
        begin
            charged = '1;
        end
        else
        begin
            charged = sum[VR_W-1:0];
        end

        for (int c = 0; c < CONTEXTS; c++)
        begin
            vr2[c]   = (IW'(c) == current_reg) ? charged : vr1[c];
            below[c] = vr2[c] < period_reg;
        end

        // Period expires when no valid non-idle context is below it.
        expired = period_on && ((vld & active & below) == '0);

        // Invalid contexts take the parked value; on expiry valid ones restart.
        for (int c = 0; c < CONTEXTS; c++)
        begin
            if (!vld[c])
            begin
                vr3[c] = mark_vr;
            end
            else if (expired)
            begin
                vr3[c] = '0;
            end
            else
            begin
                vr3[c] = vr2[c];
            end
        end

        // Scan position of each context relative to the rotation start.
        start_pos = (rot_reg == RW'(CONTEXTS)) ? '0 : IW'(rot_reg);
        for (int c = 0; c < CONTEXTS; c++)
        begin
            if (IW'(c) >= start_pos)
            begin
                pos[c] = IW'(c) - start_pos;
            end
            else
            begin
                pos[c] = IW'(c) + IW'(CONTEXTS) - start_pos;
            end
            elig[c] = vld[c] && active[c]
                      && !(s1_data_reg.skip_current && IW'(c) == current_reg);
        end
        any_elig = elig != '0;

        // Fair: least (runtime, weight, position). Round robin: least
        // (weight, position), and the first in scan order moves the start.
        for (int c = 0; c < CONTEXTS; c++)
        begin
            win_fair[c] = elig[c];
            win_rr[c]   = elig[c];
            first_rr[c] = elig[c];
            for (int d = 0; d < CONTEXTS; d++)
            begin
                if (d != c && elig[d])
                begin
                    if (vr3[d] < vr3[c]
                        || (vr3[d] == vr3[c] && prio_ctx[d] < prio_ctx[c])
                        || (vr3[d] == vr3[c] && prio_ctx[d] == prio_ctx[c]
                            && pos[d] < pos[c]))
                    begin
                        win_fair[c] = 1'b0;
                    end
                    if (prio_ctx[d] < prio_ctx[c]
                        || (prio_ctx[d] == prio_ctx[c] && pos[d] < pos[c]))
                    begin
                        win_rr[c] = 1'b0;
                    end
                    if (pos[d] < pos[c])
                    begin
                        first_rr[c] = 1'b0;
                    end
                end
            end
        end

        win = (policy_reg == POLICY_RR) ? win_rr : win_fair;
        chosen    = '0;
        first_idx = '0;
        for (int c = 0; c < CONTEXTS; c++)
        begin
            if (win[c])
            begin
                chosen = chosen | IW'(c);
            end
            if (first_rr[c])
            begin
                first_idx = first_idx | IW'(c);
            end
        end
        if (!any_elig)
        begin
            chosen = current_reg;
        end

        if (policy_reg == POLICY_RR)
        begin
            rot_next = any_elig ? RW'(first_idx) + RW'(1) : rot_reg;
        end
        else
        begin
            rot_next = RW'(chosen) + RW'(1);
        end

        prev_valid_next = vld;
        admitted_next   = kept_adm | admit;
        current_next    = chosen;
        for (int c = 0; c < CONTEXTS; c++)
        begin
            vr_next[c] = vr3[c];
        end

        // Result; an empty valid mask leaves everything alone.
        if (vld == '0)
        begin
            res_calc.chosen_context = CHOSEN_W'(current_reg);
            res_calc.no_valid       = 1'b1;
            res_calc.released_mask  = '0;
            res_calc.admitted_mask  = '0;
            res_calc.period_reset   = 1'b0;
        end
        else
        begin
            res_calc.chosen_context = CHOSEN_W'(chosen);
            res_calc.no_valid       = 1'b0;
            res_calc.released_mask  = MASK_W'(removed & admitted_reg);
            res_calc.admitted_mask  = MASK_W'(admit);
            res_calc.period_reset   = expired;
        end
    end

    assign step_en = advance && (vld != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= '0;
            admitted_reg   <= '0;
            current_reg    <= '0;
            rot_reg        <= '0;
            for (int c = 0; c < CONTEXTS; c++)
            begin
                vr_reg[c] <= '0;
            end
        end
        else if (step_en)
        begin
            prev_valid_reg <= prev_valid_next;
            admitted_reg   <= admitted_next;
            current_reg    <= current_next;
            rot_reg        <= rot_next;
            for (int c = 0; c < CONTEXTS; c++)
            begin
                vr_reg[c] <= vr_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_current_range: assert property (@(posedge clk) disable iff (!rst_n)
        current_reg <= IW'(CONTEXTS - 1))
        else $error("current context out of range");

    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rot_reg <= RW'(CONTEXTS))
        else $error("rotation start out of range");

    a_admitted_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (admitted_reg & ~prev_valid_reg) == '0)
        else $error("admitted context not in valid set");

    a_no_valid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.no_valid |->
            res_data_reg.released_mask == '0 && res_data_reg.admitted_mask == '0
            && !res_data_reg.period_reset)
        else $error("empty valid mask reported activity");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(prev_valid_reg) && $stable(current_reg)
            && $stable(rot_reg) && $stable(admitted_reg))
        else $error("scheduler state moved without a request");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
module tb_top;
    import fcs_pkg::*;

    localparam int NUM_CTX          = 4;
    localparam int RANDOM_PHASES    = 6;
    localparam int REQS_PER_PHASE   = 88;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 4;
    localparam int STUCK_LIMIT      = 2000;

    // Results that can be read straight off the scheduler's behavior.
    localparam res_t EMPTY_AT_RESET = '{chosen_context: 2'd0, no_valid: 1'b1,
                                        released_mask: 4'h0, admitted_mask: 4'h0,
                                        period_reset: 1'b0};
    localparam res_t ADMIT_ALL_AT_RESET = '{chosen_context: 2'd0, no_valid: 1'b0,
                                            released_mask: 4'h0, admitted_mask: 4'hF,
                                            period_reset: 1'b0};

    // One row of the directed plan: either a register write or a request.
    typedef struct {
        bit                   setting;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [31:0]          value;
        req_t                 req;
        bit                   known;
        res_t                 want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req_data;
    logic                  res_valid;
    logic                  res_stall;
    res_t                  res_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Scheduler state as the bench tracks it, plus the register settings.
    logic [3:0]  tracked_valid;
    logic [3:0]  tracked_admitted;
    logic [1:0]  tracked_current;
    logic [2:0]  tracked_rotation;
    logic [31:0] tracked_vruntime [NUM_CTX];
    logic [31:0] period_setting;
    logic [3:0]  weight_setting [NUM_CTX];
    logic        policy_setting;

    res_t        pending_picks [$];
    plan_row_t   plan [$];

    int          mismatches      = 0;
    int          requests_sent   = 0;
    int          empty_requests  = 0;
    int          expiries        = 0;
    int          results_checked = 0;
    int          register_writes = 0;
    int          stuck_cycles    = 0;
    bit          quiet           = 1'b0;
    bit          long_hold_due   = 1'b0;

    fair_context_scheduler #(.CONTEXTS(NUM_CTX)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // Work out the result of one dispatch request and advance the tracked
    // state exactly as the scheduler does.
    function automatic res_t schedule_dispatch(input req_t r);
        res_t        out;
        logic [3:0]  vld;
        logic [3:0]  removed;
        logic [3:0]  admit;
        logic [31:0] floor_vr;
        logic [32:0] charged;
        logic [1:0]  c;
        logic [1:0]  pick;
        logic [2:0]  first_free;
        logic [3:0]  w;
        logic [3:0]  best_w;
        logic [31:0] best_vr;
        bit          found;
        bit          expired;
        out = '0;
        vld = r.valid_mask;
        // An empty mask leaves everything as it was.
        if (vld == 4'h0)
        begin
            out.chosen_context = tracked_current;
            out.no_valid = 1'b1;
            return out;
        end

        // Release the contexts that left; clear their runtime.
        removed = tracked_valid & ~vld;
        out.released_mask = removed & tracked_admitted;
        for (int i = 0; i < NUM_CTX; i++)
        begin
            if (removed[i])
            begin
                tracked_admitted[i] = 1'b0;
                tracked_vruntime[i] = '0;
            end
        end

        // Newcomers start at the lowest runtime of the admitted valid set.
        found = 1'b0;
        floor_vr = '0;
        for (int i = 0; i < NUM_CTX; i++)
        begin
            if (vld[i] && tracked_admitted[i] && (!found || tracked_vruntime[i] < floor_vr))
            begin
                floor_vr = tracked_vruntime[i];
                found = 1'b1;
            end
        end
        admit = vld & ~tracked_valid & r.queue_ready_mask;
        for (int i = 0; i < NUM_CTX; i++)
        begin
            if (admit[i])
            begin
                tracked_vruntime[i] = floor_vr;
                tracked_admitted[i] = 1'b1;
            end
        end
        out.admitted_mask = admit;
        tracked_valid = vld;

        // Charge the current context, capped at the period or at all ones.
        charged = {1'b0, tracked_vruntime[tracked_current]}
                + 33'(weight_setting[tracked_current]);
        if (period_setting != 0 && charged >= {1'b0, period_setting})
            tracked_vruntime[tracked_current] = period_setting;
        else if (charged[32])
            tracked_vruntime[tracked_current] = 32'hFFFF_FFFF;
        else
            tracked_vruntime[tracked_current] = charged[31:0];

        // Restart the valid runtimes, parking the rest, once every valid busy context hit the period.
        expired = (period_setting != 0);
        for (int i = 0; i < NUM_CTX; i++)
        begin
            if (vld[i] && weight_setting[i] < IDLE_PRIO
                && tracked_vruntime[i] < period_setting)
                expired = 1'b0;
        end
        if (expired)
        begin
            for (int i = 0; i < NUM_CTX; i++)
                tracked_vruntime[i] = vld[i] ? 32'h0 : period_setting - 32'd1;
        end
        out.period_reset = expired;

        // Pick the next context, walking from the rotation point.
        found = 1'b0;
        pick = tracked_current;
        best_vr = '0;
        best_w = '0;
        first_free = tracked_rotation;
        for (int i = 0; i < NUM_CTX; i++)
        begin
            c = 2'(tracked_rotation + 3'(i));
            if (!vld[c])
            begin
                tracked_vruntime[c] = (period_setting != 0) ? period_setting - 32'd1 : 32'h0;
                continue;
            end
            w = weight_setting[c];
            if (w >= IDLE_PRIO)
                continue;
            if (r.skip_current && c == tracked_current)
                continue;
            if (policy_setting == POLICY_FAIR)
            begin
                if (!found || tracked_vruntime[c] < best_vr
                    || (tracked_vruntime[c] == best_vr && w < best_w))
                begin
                    found = 1'b1;
                    best_vr = tracked_vruntime[c];
                    best_w = w;
                    pick = c;
                end
            end
            else if (!found)
            begin
                found = 1'b1;
                pick = c;
                best_w = w;
                first_free = 3'(c) + 3'd1;
            end
            else if (w < best_w)
            begin
                pick = c;
                best_w = w;
            end
        end
        tracked_rotation = (policy_setting == POLICY_FAIR) ? 3'(pick) + 3'd1 : first_free;
        tracked_current = pick;
        out.chosen_context = pick;
        return out;
    endfunction

    function automatic void plan_request(input logic [3:0] vm, input logic [3:0] rdy,
                                         input logic bias, input bit known, input res_t want);
        plan_row_t row;
        row = '{default: '0};
        row.req.valid_mask = vm;
        row.req.queue_ready_mask = rdy;
        row.req.skip_current = bias;
        row.known = known;
        row.want = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_setting(input logic [REG_IDX_W-1:0] idx,
                                         input logic [31:0] value);
        plan_row_t row;
        row = '{default: '0};
        row.setting = 1'b1;
        row.reg_idx = idx;
        row.value = value;
        plan.push_back(row);
    endfunction

    // Hold off the request side; n sets how long.
    task automatic hold_requests(input int n);
        req_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (pending_picks.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Offer one request; on acceptance, queue what the scheduler should answer.
    task automatic offer_request(input req_t r, input bit known, input res_t want);
        res_t predicted;
        req_valid <= 1'b1;
        req_data <= r;
        do @(posedge clk); while (req_stall !== 1'b0);
        predicted = schedule_dispatch(r);
        pending_picks.push_back(known ? want : predicted);
        requests_sent++;
        if (r.valid_mask == 4'h0)
            empty_requests++;
        if (predicted.period_reset)
            expiries++;
        @(negedge clk);
    endtask

    // Write one register through a setup and an access cycle, only when idle.
    task automatic program_setting(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        wait_for_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PERIOD_CAP:   period_setting = value;
            REG_PRIO_CTX0:    weight_setting[0] = value[3:0];
            REG_PRIO_CTX1:    weight_setting[1] = value[3:0];
            REG_PRIO_CTX2:    weight_setting[2] = value[3:0];
            REG_PRIO_CTX3:    weight_setting[3] = value[3:0];
            REG_POLICY_MODE:  policy_setting = value[0];
            default:          ;
        endcase
        register_writes++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result with the oldest outstanding pick.
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("result with nothing outstanding: %h", res_data);
                mismatches++;
            end
            else
            begin
                want = pending_picks.pop_front();
                check_field("chosen_context", 32'(want.chosen_context),
                            32'(res_data.chosen_context));
                check_field("no_valid", 32'(want.no_valid), 32'(res_data.no_valid));
                check_field("released_mask", 32'(want.released_mask),
                            32'(res_data.released_mask));
                check_field("admitted_mask", 32'(want.admitted_mask),
                            32'(res_data.admitted_mask));
                check_field("period_reset", 32'(want.period_reset),
                            32'(res_data.period_reset));
                results_checked++;
            end
        end
    end

    // Result side: stall in random bursts, and once for a long stretch so
    // the scheduler fills up and pushes back on requests.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_due)
            begin
                res_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_due = 1'b0;
                res_stall <= 1'b0;
            end
            else if (!quiet && rst_n && $urandom_range(0, 9) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                res_stall <= 0;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin : watchdog
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid === 1'b1 && req_stall === 1'b0)
                || (res_valid === 1'b1 && res_stall === 1'b0)
                || psel === 1'b1 || rst_n !== 1'b1)
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("FAIL fair_context_scheduler");
        $finish;
    end

    // Request side: directed plan first, then randomized phases.
    initial
    begin : stimulus
        req_t       r;
        logic [3:0] live_mask;
        logic [31:0] period;
        int         roll;
        req_valid = 1'b0;
        req_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        live_mask = 4'hF;
        tracked_valid = '0;
        tracked_admitted = '0;
        tracked_current = '0;
        tracked_rotation = '0;
        period_setting = '0;
        policy_setting = POLICY_FAIR;
        for (int i = 0; i < NUM_CTX; i++)
        begin
            tracked_vruntime[i] = '0;
            weight_setting[i] = '0;
        end

        // Reset-state requests: empty mask, admit everyone, empty mask with bias.
        plan_request(4'h0, 4'h0, 1'b0, 1'b1, EMPTY_AT_RESET);
        plan_request(4'hF, 4'hF, 1'b0, 1'b1, ADMIT_ALL_AT_RESET);
        plan_request(4'h0, 4'hF, 1'b1, 1'b1, EMPTY_AT_RESET);
        // Bias skips the current context; then contexts leave and rejoin.
        plan_request(4'hF, 4'h0, 1'b1, 1'b0, '0);
        plan_request(4'h3, 4'h0, 1'b0, 1'b0, '0);
        // Rejoin with only one ready queue; the other leaves and later rejoins ready.
        plan_request(4'hF, 4'h4, 1'b0, 1'b0, '0);
        plan_request(4'h7, 4'hF, 1'b0, 1'b0, '0);
        plan_request(4'hF, 4'hF, 1'b0, 1'b0, '0);
        // Short period, weights straddling the idle threshold.
        plan_setting(REG_PERIOD_CAP, 32'd3);
        plan_setting(REG_PRIO_CTX0, 32'd15);
        plan_setting(REG_PRIO_CTX1, 32'd4);
        plan_setting(REG_PRIO_CTX2, 32'd5);
        plan_setting(REG_PRIO_CTX3, 32'd1);
        plan_request(4'hF, 4'h0, 1'b0, 1'b0, '0);
        plan_request(4'hF, 4'h0, 1'b0, 1'b0, '0);
        plan_request(4'hF, 4'h0, 1'b1, 1'b0, '0);
        plan_request(4'hF, 4'h0, 1'b0, 1'b0, '0);
        plan_request(4'hF, 4'h0, 1'b0, 1'b0, '0);
        plan_request(4'hF, 4'h0, 1'b0, 1'b0, '0);
        // Round robin with the priority override.
        plan_setting(REG_POLICY_MODE, 32'(POLICY_RR));
        plan_request(4'hF, 4'h0, 1'b0, 1'b0, '0);
        plan_request(4'hF, 4'h0, 1'b1, 1'b0, '0);
        plan_request(4'hB, 4'h0, 1'b0, 1'b0, '0);
        plan_request(4'hF, 4'hF, 1'b0, 1'b0, '0);
        // Widest period: invalid contexts park just below all ones.
        plan_setting(REG_PERIOD_CAP, 32'hFFFF_FFFF);
        plan_setting(REG_PRIO_CTX1, 32'd0);
        plan_setting(REG_PRIO_CTX3, 32'd0);
        plan_request(4'h6, 4'h0, 1'b0, 1'b0, '0);
        plan_request(4'h6, 4'h0, 1'b0, 1'b0, '0);
        // Period off: a parked context rejoins unadmitted, gets picked, then
        // saturates at all ones; with everyone idle the current one is kept.
        plan_setting(REG_PERIOD_CAP, 32'd0);
        plan_setting(REG_POLICY_MODE, 32'(POLICY_FAIR));
        plan_setting(REG_PRIO_CTX1, 32'd15);
        plan_setting(REG_PRIO_CTX2, 32'd15);
        plan_request(4'hF, 4'h0, 1'b0, 1'b0, '0);
        plan_setting(REG_PRIO_CTX3, 32'd15);
        plan_request(4'hF, 4'h0, 1'b0, 1'b0, '0);
        plan_request(4'hF, 4'h0, 1'b1, 1'b0, '0);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[k])
        begin
            if (plan[k].setting)
                program_setting(plan[k].reg_idx, plan[k].value);
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    hold_requests($urandom_range(1, 12));
                offer_request(plan[k].req, plan[k].known, plan[k].want);
            end
        end

        // Each phase: fresh settings, then mostly stable masks with occasional
        // joins, leaves and empty requests so runtimes build up and expire.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       period = 32'd1;
                1:       period = $urandom_range(2, 24);
                2:       period = 32'd0;
                3:       period = 32'hFFFF_FFFF;
                4:       period = $urandom;
                default: period = $urandom_range(3, 40);
            endcase
            program_setting(REG_PERIOD_CAP, period);
            program_setting(REG_PRIO_CTX0, ($urandom_range(0, 2) == 0) ?
                            $urandom_range(5, 15) : $urandom_range(0, 4));
            program_setting(REG_PRIO_CTX1, ($urandom_range(0, 2) == 0) ?
                            $urandom_range(5, 15) : $urandom_range(0, 4));
            program_setting(REG_PRIO_CTX2, ($urandom_range(0, 2) == 0) ?
                            $urandom_range(5, 15) : $urandom_range(0, 4));
            program_setting(REG_PRIO_CTX3, ($urandom_range(0, 2) == 0) ?
                            $urandom_range(5, 15) : $urandom_range(0, 4));
            program_setting(REG_POLICY_MODE, phase[0] ? 32'(POLICY_RR) : 32'(POLICY_FAIR));
            // Run the last phase back to back on both sides.
            quiet = (phase == RANDOM_PHASES - 1);

            for (int n = 0; n < REQS_PER_PHASE; n++)
            begin
                if (phase == 1 && n == 30)
                    long_hold_due = 1'b1;
                if (phase == 2 && n == 45)
                    wait_for_results();
                if (!quiet && $urandom_range(0, 7) == 0)
                    hold_requests($urandom_range(1, 12));
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    r.valid_mask = 4'h0;
                else
                begin
                    if (roll < 26)
                        live_mask = live_mask ^ 4'($urandom_range(1, 15));
                    r.valid_mask = live_mask;
                end
                r.queue_ready_mask = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'hF;
                r.skip_current = ($urandom_range(0, 4) == 0);
                offer_request(r, 1'b0, '0);
            end
        end

        // Drain, let the pipeline settle, then report.
        wait_for_results();
        repeat (8) @(negedge clk);
        $display("Covered %0d requests (%0d with an empty mask), %0d results checked",
                 requests_sent, empty_requests, results_checked);
        $display("Saw %0d period expiries over %0d register writes, fair and round robin",
                 expiries, register_writes);
        if (mismatches == 0 && pending_picks.size() == 0)
            $display("PASS fair_context_scheduler");
        else
            $display("FAIL fair_context_scheduler");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/fcs_pkg.sv
hw/rtl/fair_context_scheduler.sv
bench/tb_top.sv
